@@ src/hdlc_bit_stuff_nrzi_encoder_assert.svh @@
// Assertion macros for the HDLC bit-stuff NRZI encoder checks
`ifndef HDLC_BIT_STUFF_NRZI_ENCODER_ASSERT_SVH
`define HDLC_BIT_STUFF_NRZI_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define HBS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbs check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define HBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbs check failed");

`endif

@@ src/hbs_pkg.sv @@
// Shared types and constants of the HDLC bit-stuff NRZI encoder
package hbs_pkg;

    localparam int MAX_BITS = 4096;
    localparam int BITS_W   = $clog2(MAX_BITS + 1);

    localparam int ACTION_W = 2;
    localparam logic [ACTION_W-1:0] ACT_OPEN   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DATA   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLOSE  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam int         STUFF_RUN   = 5;
    localparam int         CLOSE_FLAGS = 3;

    localparam int ONES_W = 3;
    localparam int POS_W  = 5;
    localparam logic [POS_W-1:0] BYTE_LAST_POS  = POS_W'(7);
    localparam logic [POS_W-1:0] STUFF_LAST_POS = POS_W'(8);
    localparam logic [POS_W-1:0] CLOSE_LAST_POS = POS_W'(8 * CLOSE_FLAGS - 1);

    // One classified item waiting for the serializer
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                new_frame;
        logic [7:0]          data_byte;
    } hbs_entry_t;

    typedef struct packed {
        logic       push;
        hbs_entry_t entry;
    } hbs_push_t;

    typedef struct packed {
        logic       valid;
        hbs_entry_t entry;
    } hbs_head_t;

endpackage

@@ src/hbs_if.sv @@
// Valid/ready channel interfaces for frame items and line results
interface hbs_in_if import hbs_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                new_frame;
    logic [7:0]          data_byte;

    modport source (output valid, output action, output new_frame, output data_byte,
                    input ready);
    modport sink   (input valid, input action, input new_frame, input data_byte,
                    output ready);
endinterface

interface hbs_out_if;
    logic valid;
    logic ready;
    logic tone;
    logic last;
    logic overflow;

    modport source (output valid, output tone, output last, output overflow, input ready);
    modport sink   (input valid, input tone, input last, input overflow, output ready);
endinterface

@@ src/hbs_front.sv @@
// Front end: accepts frame items, drops the unused action code, queues the rest
module hbs_front import hbs_pkg::*;
(
    hbs_in_if.sink    frame,
    input  logic      full,
    output hbs_push_t push
);

    always_comb
    begin
        frame.ready           = !full;
        push.push             = frame.valid && !full && (frame.action != ACT_UNUSED);
        push.entry.action     = frame.action;
        // new_frame only means something on an opening flag
        push.entry.new_frame  = frame.new_frame && (frame.action == ACT_OPEN);
        push.entry.data_byte  = frame.data_byte;
    end

endmodule

@@ src/hbs_queue.sv @@
// Two-entry item queue between the classifier and the serializer
module hbs_queue import hbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hbs_push_t push,
    input  logic      pop,
    output logic      full,
    output hbs_head_t head
);

    hbs_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push.push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push.push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/hbs_back.sv @@
// Back end: bit serializer with stuffing, NRZI level, bit limit and output register
module hbs_back import hbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hbs_head_t head,
    output logic      pop,
    hbs_out_if.source line
);

    logic              level_reg, level_next;
    logic [ONES_W-1:0] ones_reg, ones_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    logic              limit_reg, limit_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              stuff_reg, stuff_next;
    logic              out_valid_reg, out_valid_next;
    logic              tone_reg, tone_next;
    logic              last_reg, last_next;
    logic              ovf_reg, ovf_next;

    assign line.valid    = out_valid_reg;
    assign line.tone     = tone_reg;
    assign line.last     = last_reg;
    assign line.overflow = ovf_reg;

    always_comb
    begin
        logic              step;
        logic              restart;
        logic              eff_level;
        logic [ONES_W-1:0] eff_ones;
        logic [BITS_W-1:0] eff_bits;
        logic              eff_limit;
        logic              bit_val;
        logic              done;
        logic [ONES_W-1:0] ones_inc;

        step    = head.valid && (!out_valid_reg || line.ready);
        // new frame resets the line state before its first bit
        restart = (pos_reg == '0) && !stuff_reg && (head.entry.action == ACT_OPEN)
                  && head.entry.new_frame;
        eff_level = restart ? 1'b1 : level_reg;
        eff_ones  = restart ? '0 : ones_reg;
        eff_bits  = restart ? '0 : bits_reg;
        eff_limit = restart ? 1'b0 : limit_reg;

        bit_val  = 1'b0;
        done     = 1'b0;
        ones_inc = eff_ones + ONES_W'(1);

        level_next     = level_reg;
        ones_next      = ones_reg;
        bits_next      = bits_reg;
        limit_next     = limit_reg;
        pos_next       = pos_reg;
        stuff_next     = stuff_reg;
        out_valid_next = out_valid_reg && !line.ready;
        tone_next      = tone_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;

        if (step)
        begin
            out_valid_next = 1'b1;
            level_next     = eff_level;
            ones_next      = eff_ones;
            bits_next      = eff_bits;
            if (eff_limit || (eff_bits == BITS_W'(MAX_BITS)))
            begin
                // a bit is due but the frame is out of budget
                limit_next = 1'b1;
                done       = 1'b1;
                tone_next  = 1'b0;
                last_next  = 1'b1;
                ovf_next   = 1'b1;
            end
            else
            begin
                limit_next = 1'b0;
                if (stuff_reg)
                begin
                    bit_val    = 1'b0;
                    ones_next  = '0;
                    stuff_next = 1'b0;
                    done       = (pos_reg == STUFF_LAST_POS);
                end
                else if (head.entry.action == ACT_DATA)
                begin
                    bit_val    = head.entry.data_byte[pos_reg[2:0]];
                    ones_next  = bit_val ? ones_inc : '0;
                    stuff_next = bit_val && (ones_inc == ONES_W'(STUFF_RUN));
                    done       = (pos_reg == BYTE_LAST_POS) && !stuff_next;
                    pos_next   = pos_reg + POS_W'(1);
                end
                else
                begin
                    bit_val   = FLAG_BYTE[pos_reg[2:0]];
                    ones_next = '0;
                    done      = (head.entry.action == ACT_OPEN) ? (pos_reg == BYTE_LAST_POS)
                                                               : (pos_reg == CLOSE_LAST_POS);
                    pos_next  = pos_reg + POS_W'(1);
                end
                level_next = eff_level ^ !bit_val;
                bits_next  = eff_bits + BITS_W'(1);
                tone_next  = eff_level ^ !bit_val;
                last_next  = done;
                ovf_next   = 1'b0;
            end
            if (done)
            begin
                pos_next   = '0;
                stuff_next = 1'b0;
            end
        end
        pop = step && done;
    end

    always_ff @(posedge clk)
    begin
        tone_reg <= tone_next;
        last_reg <= last_next;
        ovf_reg  <= ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= 1'b1;
            ones_reg      <= '0;
            bits_reg      <= '0;
            limit_reg     <= 1'b0;
            pos_reg       <= '0;
            stuff_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            ones_reg      <= ones_next;
            bits_reg      <= bits_next;
            limit_reg     <= limit_next;
            pos_reg       <= pos_next;
            stuff_reg     <= stuff_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/hdlc_bit_stuff_nrzi_encoder.sv @@
// HDLC bit-stuff NRZI encoder: one line bit per cycle from frame items while
// the line is ready. A classifier takes frame items into a two-entry queue and
// drops action code 3; a serializer emits one NRZI level per clock, while the
// line is ready, from the queue head into an output register. An opening flag
// is 8 line bits, a data byte 8 to 10 (one more per stuffed zero), a closing
// sequence 24; an item stopped by the bit limit ends in one overflow result. The
// serializer sets the rate; an item starts once the one before it is popped.
module hdlc_bit_stuff_nrzi_encoder import hbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hbs_in_if.sink    frame,
    hbs_out_if.source line
);

    hbs_push_t push;
    hbs_head_t head;
    logic      full;
    logic      pop;

    hbs_front u_front
    (
        .frame (frame),
        .full  (full),
        .push  (push)
    );

    hbs_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (full),
        .head  (head)
    );

    hbs_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .line  (line)
    );

endmodule

@@ src/hbs_checker.sv @@
// Port-level checks on the encoder's line output, bound to the top level
`include "hdlc_bit_stuff_nrzi_encoder_assert.svh"

module hbs_checker
(
    input logic clk,
    input logic rst_n,
    input logic valid,
    input logic ready,
    input logic tone,
    input logic last,
    input logic overflow
);

    // an overflow result always closes its item and carries space
    `HBS_ASSERT_NOW(a_ovf_closes, valid && overflow, last && !tone)
    // bits of one item come back to back while the line takes them
    `HBS_ASSERT_NEXT(a_item_gapless, valid && ready && !last, valid)
    `HBS_ASSERT_NEXT(a_stall_holds, valid && !ready,
        valid && $stable(tone) && $stable(last) && $stable(overflow))

endmodule

bind hdlc_bit_stuff_nrzi_encoder hbs_checker u_hbs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .valid    (line.valid),
    .ready    (line.ready),
    .tone     (line.tone),
    .last     (line.last),
    .overflow (line.overflow)
);
